FILE: hdl/dww_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dww_pkg: shared types and constants of the display window write parser.
// Holds the command codes, panel limits and the configuration bundle.
// ----------------------------------------------------------------------------
package dww_pkg;

  localparam int unsigned PanelRegW = 11;
  localparam logic [PanelRegW-1:0] PanelMax = 11'd1024;
  localparam logic [PanelRegW-1:0] PanelReset = 11'd50;

  localparam logic [7:0] CmdColumnSet = 8'h2A;
  localparam logic [7:0] CmdRowSet = 8'h2B;
  localparam logic [7:0] CmdMemWrite = 8'h2C;

  localparam logic [0:0] RegPanelWidth = 1'b0;
  localparam logic [0:0] RegPanelHeight = 1'b1;

  typedef struct packed {
    logic [PanelRegW-1:0] panel_width;
    logic [PanelRegW-1:0] panel_height;
  } cfg_t;

endpackage

FILE: hdl/dww_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dww_if: valid/ready channels of the display window write parser.
// One channel carries stream bytes, the other carries pixel writes.
// ----------------------------------------------------------------------------
interface dww_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] stream_byte;

  modport source (output valid, output stream_byte, input ready);
  modport sink (input valid, input stream_byte, output ready);
endinterface

interface dww_pixel_if;
  logic        valid;
  logic        ready;
  logic [9:0]  pixel_column;
  logic [9:0]  pixel_row;
  logic [19:0] pixel_index;
  logic [31:0] pixel_argb;

  modport source (output valid, output pixel_column, output pixel_row,
                  output pixel_index, output pixel_argb, input ready);
  modport sink (input valid, input pixel_column, input pixel_row,
                input pixel_index, input pixel_argb, output ready);
endinterface

FILE: hdl/dww_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dww_cfg_regs: APB register file for the panel size.
// Register 0 is the panel width and register 1 the panel height.
// ----------------------------------------------------------------------------
module dww_cfg_regs (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  output dww_pkg::cfg_t       cfg_o
);

  logic [dww_pkg::PanelRegW-1:0] width_q;
  logic [dww_pkg::PanelRegW-1:0] height_q;
  logic                          wr_en;

  assign pready = 1'b1;
  assign wr_en = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= dww_pkg::PanelReset;
      height_q <= dww_pkg::PanelReset;
    end else if (wr_en) begin
      case (paddr[2])
        dww_pkg::RegPanelWidth: width_q <= pwdata[dww_pkg::PanelRegW-1:0];
        dww_pkg::RegPanelHeight: height_q <= pwdata[dww_pkg::PanelRegW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      dww_pkg::RegPanelWidth: prdata = {21'd0, width_q};
      dww_pkg::RegPanelHeight: prdata = {21'd0, height_q};
      default: prdata = '0;
    endcase
  end

  assign cfg_o.panel_width = width_q;
  assign cfg_o.panel_height = height_q;

endmodule

FILE: hdl/dww_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dww_parser: command parser and pixel write generator.
// An input register holds one stream byte; the parser consumes it and
// loads the result register when a pixel lands on the panel.
// ----------------------------------------------------------------------------
module dww_parser (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  dww_pkg::cfg_t cfg_i,
  dww_byte_if.sink      stream_i,
  dww_pixel_if.source   pixel_o
);

  typedef enum logic [3:0] {
    PH_CMD   = 4'd0,
    PH_CS_HI = 4'd1,
    PH_CS_LO = 4'd2,
    PH_CE_HI = 4'd3,
    PH_CE_LO = 4'd4,
    PH_RS_HI = 4'd5,
    PH_RS_LO = 4'd6,
    PH_RE_HI = 4'd7,
    PH_RE_LO = 4'd8,
    PH_PX_HI = 4'd9,
    PH_PX_LO = 4'd10
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [15:0] col_start_q, col_start_d;
  logic [15:0] col_end_q, col_end_d;
  logic [15:0] row_start_q, row_start_d;
  logic [15:0] row_end_q, row_end_d;
  logic [15:0] cur_col_q, cur_col_d;
  logic [15:0] cur_row_q, cur_row_d;
  logic [7:0]  held_q, held_d;

  logic        in_valid_q;
  logic [7:0]  byte_q;
  logic        in_ready;
  logic        advance;

  logic        out_valid_q;
  logic [9:0]  out_col_q;
  logic [9:0]  out_row_q;
  logic [19:0] out_index_q;
  logic [31:0] out_argb_q;

  logic [15:0] word;
  logic [10:0] eff_w, eff_h;
  logic        on_panel;
  logic        emit;
  logic [20:0] row_base;
  logic [19:0] index_d;
  logic [31:0] argb_d;

  assign advance  = in_valid_q & (~out_valid_q | pixel_o.ready);
  assign in_ready = ~in_valid_q | advance;
  assign stream_i.ready = in_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready) begin
      in_valid_q <= stream_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready && stream_i.valid) begin
      byte_q <= stream_i.stream_byte;
    end
  end

  assign word  = {held_q, byte_q};
  assign eff_w = (cfg_i.panel_width > dww_pkg::PanelMax) ? dww_pkg::PanelMax
                                                          : cfg_i.panel_width;
  assign eff_h = (cfg_i.panel_height > dww_pkg::PanelMax) ? dww_pkg::PanelMax
                                                           : cfg_i.panel_height;
  assign on_panel = (cur_row_q < {5'd0, eff_h}) && (cur_col_q < {5'd0, eff_w});
  assign row_base = {11'd0, cur_row_q[9:0]} * {10'd0, eff_w};
  assign index_d  = row_base[19:0] + {10'd0, cur_col_q[9:0]};
  assign argb_d   = {8'hFF,
                     word[15:11], word[15:13],
                     word[10:5], word[10:9],
                     word[4:0], word[4:2]};
  assign emit = (phase_q == PH_PX_LO) && on_panel;

  always_comb begin
    phase_d     = phase_q;
    col_start_d = col_start_q;
    col_end_d   = col_end_q;
    row_start_d = row_start_q;
    row_end_d   = row_end_q;
    cur_col_d   = cur_col_q;
    cur_row_d   = cur_row_q;
    held_d      = held_q;
    case (phase_q)
      PH_CS_HI: begin
        held_d  = byte_q;
        phase_d = PH_CS_LO;
      end
      PH_CE_HI: begin
        held_d  = byte_q;
        phase_d = PH_CE_LO;
      end
      PH_RS_HI: begin
        held_d  = byte_q;
        phase_d = PH_RS_LO;
      end
      PH_RE_HI: begin
        held_d  = byte_q;
        phase_d = PH_RE_LO;
      end
      PH_PX_HI: begin
        held_d  = byte_q;
        phase_d = PH_PX_LO;
      end
      PH_CS_LO: begin
        col_start_d = word;
        phase_d     = PH_CE_HI;
      end
      PH_CE_LO: begin
        col_end_d = word;
        phase_d   = PH_CMD;
      end
      PH_RS_LO: begin
        row_start_d = word;
        phase_d     = PH_RE_HI;
      end
      PH_RE_LO: begin
        row_end_d = word;
        phase_d   = PH_CMD;
      end
      PH_PX_LO: begin
        if (cur_col_q == col_end_q) begin
          cur_col_d = col_start_q;
          if (cur_row_q == row_end_q) begin
            phase_d = PH_CMD;
          end else begin
            cur_row_d = cur_row_q + 16'd1;
            phase_d   = PH_PX_HI;
          end
        end else begin
          cur_col_d = cur_col_q + 16'd1;
          phase_d   = PH_PX_HI;
        end
      end
      default: begin
        phase_d = PH_CMD;
        if (byte_q == dww_pkg::CmdColumnSet) begin
          phase_d = PH_CS_HI;
        end else if (byte_q == dww_pkg::CmdRowSet) begin
          phase_d = PH_RS_HI;
        end else if (byte_q == dww_pkg::CmdMemWrite) begin
          if (col_end_q >= col_start_q && row_end_q >= row_start_q) begin
            cur_col_d = col_start_q;
            cur_row_d = row_start_q;
            phase_d   = PH_PX_HI;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_CMD;
      col_start_q <= '0;
      col_end_q   <= '0;
      row_start_q <= '0;
      row_end_q   <= '0;
      cur_col_q   <= '0;
      cur_row_q   <= '0;
      held_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (advance) begin
        phase_q     <= phase_d;
        col_start_q <= col_start_d;
        col_end_q   <= col_end_d;
        row_start_q <= row_start_d;
        row_end_q   <= row_end_d;
        cur_col_q   <= cur_col_d;
        cur_row_q   <= cur_row_d;
        held_q      <= held_d;
        out_valid_q <= emit;
      end else if (pixel_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && emit) begin
      out_col_q   <= cur_col_q[9:0];
      out_row_q   <= cur_row_q[9:0];
      out_index_q <= index_d;
      out_argb_q  <= argb_d;
    end
  end

  assign pixel_o.valid        = out_valid_q;
  assign pixel_o.pixel_column = out_col_q;
  assign pixel_o.pixel_row    = out_row_q;
  assign pixel_o.pixel_index  = out_index_q;
  assign pixel_o.pixel_argb   = out_argb_q;

`ifndef SYNTHESIS
  a_alpha_opaque: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> out_argb_q[31:24] == 8'hFF)
    else $error("pixel write without opaque alpha");

  a_emit_from_pixel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !$past(out_valid_q)) |-> $past(phase_q) == PH_PX_LO)
    else $error("pixel write outside the pixel low byte");

  a_row_in_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_PX_HI || phase_q == PH_PX_LO) |->
      (cur_row_q >= row_start_q && cur_row_q <= row_end_q))
    else $error("current row outside the window");

  a_col_in_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_PX_HI || phase_q == PH_PX_LO) |->
      (cur_col_q >= col_start_q && cur_col_q <= col_end_q))
    else $error("current column outside the window");
`endif

endmodule

FILE: hdl/display_window_write_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// display_window_write_parser: display command stream to pixel writes.
// Parses column and row window commands and memory write pixel data.
// ----------------------------------------------------------------------------
// The stream_i channel takes one command, parameter or pixel byte per item.
// The pixel_o channel gives one item per pixel that lands on the panel, with
// its column, row, linear index and ARGB8888 color. The APB port holds the
// panel width and height; write them only while the block is idle.
// A byte is registered at acceptance and parsed from the input register,
// which also loads the output register, so a pixel write becomes valid once
// its low byte has left the input register. One byte is accepted per cycle
// unless a stall fills both registers; the input register and the output
// register let a new byte enter while a finished pixel write still waits.
// The row times width product sits between them and sets the cycle time.
// When the receiver stalls, stream_i.ready drops only once both registers
// hold items. Reset empties both registers, sets the parser to await a
// command, clears the window to zero and loads a panel size of 50 by 50.
// ----------------------------------------------------------------------------
module display_window_write_parser (
  input  logic         clk_i,
  input  logic         rst_ni,
  dww_byte_if.sink     stream_i,
  dww_pixel_if.source  pixel_o,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  dww_pkg::cfg_t cfg;

  dww_cfg_regs u_cfg_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  dww_parser u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .stream_i (stream_i),
    .pixel_o  (pixel_o)
  );

endmodule

FILE: sim/pixel_write_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pixel_write_checker: predicts and checks the pixel writes of the parser.
// Watches the byte channel, the pixel channel and the APB writes. It keeps
// its own copy of the parse state and panel size and compares every pixel
// write, field by field, against the oldest predicted one.
// ----------------------------------------------------------------------------
module pixel_write_checker
  import dww_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  dww_byte_if         stream_mon,
  dww_pixel_if        pixel_mon,
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic        pready_i,
  input  logic [2:0]  paddr_i,
  input  logic [31:0] pwdata_i,
  output int unsigned mismatch_count_o,
  output int unsigned pending_writes_o,
  output int unsigned writes_checked_o
);

  typedef enum logic [3:0] {
    AwaitCommand,
    ColStartHi,
    ColStartLo,
    ColEndHi,
    ColEndLo,
    RowStartHi,
    RowStartLo,
    RowEndHi,
    RowEndLo,
    PixelHi,
    PixelLo
  } parse_phase_e;

  typedef struct packed {
    logic [9:0]  column;
    logic [9:0]  row;
    logic [19:0] index;
    logic [31:0] argb;
  } pixel_write_t;

  parse_phase_e         phase;
  logic [15:0]          col_start, col_end, row_start, row_end;
  logic [15:0]          cur_col, cur_row;
  logic [7:0]           held_byte;
  logic [PanelRegW-1:0] panel_width, panel_height;
  pixel_write_t         expected_writes[$];

  function automatic void parse_stream_byte(logic [7:0] b);
    logic [15:0]          word;
    logic [PanelRegW-1:0] w, h;
    logic [31:0]          addr;
    pixel_write_t         wr;
    word = {held_byte, b};
    case (phase)
      ColStartHi, ColEndHi, RowStartHi, RowEndHi, PixelHi: begin
        held_byte = b;
        phase = parse_phase_e'(phase + 4'd1);
      end
      ColStartLo: begin
        col_start = word;
        phase = ColEndHi;
      end
      ColEndLo: begin
        col_end = word;
        phase = AwaitCommand;
      end
      RowStartLo: begin
        row_start = word;
        phase = RowEndHi;
      end
      RowEndLo: begin
        row_end = word;
        phase = AwaitCommand;
      end
      PixelLo: begin
        w = (panel_width > PanelMax) ? PanelMax : panel_width;
        h = (panel_height > PanelMax) ? PanelMax : panel_height;
        if (cur_row < 16'(h) && cur_col < 16'(w)) begin
          addr = 32'(cur_row) * 32'(w) + 32'(cur_col);
          wr.column = cur_col[9:0];
          wr.row = cur_row[9:0];
          wr.index = addr[19:0];
          // RGB565 to ARGB8888: each channel's top bits are repeated below it.
          wr.argb = {8'hFF, word[15:11], word[15:13], word[10:5], word[10:9],
                     word[4:0], word[4:2]};
          expected_writes.push_back(wr);
        end
        if (cur_col == col_end) begin
          cur_col = col_start;
          if (cur_row == row_end) begin
            phase = AwaitCommand;
          end else begin
            cur_row = cur_row + 16'd1;
            phase = PixelHi;
          end
        end else begin
          cur_col = cur_col + 16'd1;
          phase = PixelHi;
        end
      end
      default: begin
        phase = AwaitCommand;
        if (b == CmdColumnSet) begin
          phase = ColStartHi;
        end else if (b == CmdRowSet) begin
          phase = RowStartHi;
        end else if (b == CmdMemWrite && col_end >= col_start && row_end >= row_start) begin
          cur_col = col_start;
          cur_row = row_start;
          phase = PixelHi;
        end
      end
    endcase
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    pixel_write_t got, want;
    if (!rst_ni) begin
      phase = AwaitCommand;
      col_start = '0;
      col_end = '0;
      row_start = '0;
      row_end = '0;
      cur_col = '0;
      cur_row = '0;
      held_byte = '0;
      panel_width = PanelReset;
      panel_height = PanelReset;
      expected_writes.delete();
      mismatch_count_o = 0;
      pending_writes_o = 0;
      writes_checked_o = 0;
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (paddr_i[2:2])
          RegPanelWidth: panel_width = pwdata_i[PanelRegW-1:0];
          RegPanelHeight: panel_height = pwdata_i[PanelRegW-1:0];
          default: ;
        endcase
      end
      if (pixel_mon.valid && pixel_mon.ready) begin
        got.column = pixel_mon.pixel_column;
        got.row = pixel_mon.pixel_row;
        got.index = pixel_mon.pixel_index;
        got.argb = pixel_mon.pixel_argb;
        if (expected_writes.size() == 0) begin
          $error("pixel write with none expected: column %0d, row %0d", got.column,
                 got.row);
          mismatch_count_o++;
        end else begin
          want = expected_writes.pop_front();
          writes_checked_o++;
          if (got.column !== want.column) begin
            $error("pixel_column: expected %0d, got %0d", want.column, got.column);
            mismatch_count_o++;
          end
          if (got.row !== want.row) begin
            $error("pixel_row: expected %0d, got %0d", want.row, got.row);
            mismatch_count_o++;
          end
          if (got.index !== want.index) begin
            $error("pixel_index: expected %0d, got %0d", want.index, got.index);
            mismatch_count_o++;
          end
          if (got.argb !== want.argb) begin
            $error("pixel_argb: expected %08h, got %08h", want.argb, got.argb);
            mismatch_count_o++;
          end
        end
      end
      if (stream_mon.valid && stream_mon.ready) begin
        parse_stream_byte(stream_mon.stream_byte);
      end
      pending_writes_o = expected_writes.size();
    end
  end

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: command stream stimulus for the display window write parser.
// Sends column and row window commands and memory writes with random pixels
// and random window placement around the panel edges, under several panel
// sizes. Both channels idle at random; a separate checker judges the writes.
// ----------------------------------------------------------------------------
module testbench;
  import dww_pkg::*;

  localparam int unsigned CycleLimit = 1_000_000;
  localparam int unsigned PhaseQuota = 200;
  localparam int unsigned NumSettings = 7;
  localparam logic [PanelRegW-1:0] SettingW [NumSettings] =
    '{11'd1, 11'd1024, 11'd2047, 11'd0, 11'd300, 11'd1023, 11'd77};
  localparam logic [PanelRegW-1:0] SettingH [NumSettings] =
    '{11'd1, 11'd1024, 11'd7, 11'd1024, 11'd2047, 11'd1023, 11'd64};

  logic        clk, rst_n;
  logic        psel, penable, pwrite, pready;
  logic [2:0]  paddr;
  logic [31:0] pwdata, prdata;

  dww_byte_if  stream_if ();
  dww_pixel_if pixel_if ();

  int unsigned mismatch_count, pending_writes, writes_checked;
  int unsigned cycle_count = 0;
  int unsigned counted_bytes = 0, ignored_bytes = 0, phase_bytes = 0;
  int unsigned empty_writes = 0, gapless_items = 0;
  int unsigned eff_w, eff_h;
  logic [15:0] win_col_lo, win_col_hi, win_row_lo, win_row_hi;

  display_window_write_parser DUT (
    .clk_i    (clk),
    .rst_ni   (rst_n),
    .stream_i (stream_if),
    .pixel_o  (pixel_if),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  pixel_write_checker checker_inst (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .stream_mon       (stream_if),
    .pixel_mon        (pixel_if),
    .psel_i           (psel),
    .penable_i        (penable),
    .pwrite_i         (pwrite),
    .pready_i         (pready),
    .paddr_i          (paddr),
    .pwdata_i         (pwdata),
    .mismatch_count_o (mismatch_count),
    .pending_writes_o (pending_writes),
    .writes_checked_o (writes_checked)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CycleLimit) begin
      $error("run stopped after %0d cycles with %0d writes pending", cycle_count,
             pending_writes);
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin : write_sink
    int run, stall;
    pixel_if.ready = 1'b0;
    wait (rst_n);
    @(negedge clk);
    forever begin
      run = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 200) : $urandom_range(1, 8);
      pixel_if.ready <= 1'b1;
      repeat (run) @(negedge clk);
      case ($urandom_range(0, 9))
        0, 1, 2: stall = 0;
        9: stall = $urandom_range(8, 40);
        default: stall = $urandom_range(1, 3);
      endcase
      if (stall > 0) begin
        pixel_if.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input bit counted);
    int gap;
    if (gapless_items > 0) begin
      gapless_items--;
      gap = 0;
    end else begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: gap = 0;
        9: gap = $urandom_range(8, 40);
        default: gap = $urandom_range(1, 3);
      endcase
    end
    if (gap > 0) begin
      stream_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    stream_if.valid <= 1'b1;
    stream_if.stream_byte <= b;
    do @(posedge clk); while (!stream_if.ready);
    @(negedge clk);
    if (counted) begin
      counted_bytes++;
      phase_bytes++;
    end else begin
      ignored_bytes++;
    end
  endtask

  task automatic load_window(input logic [7:0] cmd, input logic [15:0] lo,
                             input logic [15:0] hi);
    send_byte(cmd, 1'b1);
    send_byte(lo[15:8], 1'b1);
    send_byte(lo[7:0], 1'b1);
    send_byte(hi[15:8], 1'b1);
    send_byte(hi[7:0], 1'b1);
    if (cmd == CmdColumnSet) begin
      win_col_lo = lo;
      win_col_hi = hi;
    end else begin
      win_row_lo = lo;
      win_row_hi = hi;
    end
  endtask

  task automatic write_pixels();
    int unsigned cols, rows;
    logic [15:0] p;
    send_byte(CmdMemWrite, 1'b1);
    cols = (win_col_hi >= win_col_lo) ? win_col_hi - win_col_lo + 1 : 0;
    rows = (win_row_hi >= win_row_lo) ? win_row_hi - win_row_lo + 1 : 0;
    if (cols * rows == 0) empty_writes++;
    repeat (cols * rows) begin
      case ($urandom_range(0, 15))
        0: p = 16'h0000;
        1: p = 16'hFFFF;
        2: p = 16'hF800;
        3: p = 16'h07E0;
        4: p = 16'h001F;
        default: p = 16'($urandom);
      endcase
      send_byte(p[15:8], 1'b1);
      send_byte(p[7:0], 1'b1);
    end
  endtask

  task automatic wait_until_drained();
    stream_if.valid <= 1'b0;
    while (pending_writes != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_panel_reg(input logic [2:0] addr, input logic [PanelRegW-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= {21'($urandom), value};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
  endtask

  task automatic set_panel(input logic [PanelRegW-1:0] w, input logic [PanelRegW-1:0] h);
    write_panel_reg({RegPanelWidth, 2'b00}, w);
    write_panel_reg({RegPanelHeight, 2'b00}, h);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    eff_w = (w > PanelMax) ? PanelMax : w;
    eff_h = (h > PanelMax) ? PanelMax : h;
  endtask

  function automatic logic [15:0] pick_start(int unsigned limit);
    case ($urandom_range(0, 5))
      0: return 16'd0;
      1: return (limit >= 3) ? 16'(limit - 3 + $urandom_range(0, 5)) : 16'($urandom_range(0, 5));
      2: return (limit > 0) ? 16'($urandom_range(0, limit - 1)) : 16'd0;
      3: return 16'hFFFF - 16'($urandom_range(0, 7));
      4: return 16'($urandom_range(1000, 1023));
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic logic [15:0] pick_end(logic [15:0] lo, int unsigned longest);
    if (lo >= 16'd3 && $urandom_range(0, 9) == 0) return lo - 16'($urandom_range(1, 3));
    if ($urandom_range(0, 4) == 0) return lo + 16'($urandom_range(0, longest));
    return lo + 16'($urandom_range(0, 3));
  endfunction

  initial begin : stimulus
    int unsigned r;
    logic [15:0] lo;
    logic [7:0]  noise;
    bit          paused;
    stream_if.valid = 1'b0;
    stream_if.stream_byte = 8'h00;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    rst_n = 1'b0;
    eff_w = PanelReset;
    eff_h = PanelReset;
    win_col_lo = '0;
    win_col_hi = '0;
    win_row_lo = '0;
    win_row_hi = '0;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Stray bytes, a two-pixel write of red and cyan, then an empty window.
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    load_window(CmdColumnSet, 16'd0, 16'd1);
    load_window(CmdRowSet, 16'd0, 16'd0);
    send_byte(CmdMemWrite, 1'b1);
    send_byte(8'hF8, 1'b1);
    send_byte(8'h00, 1'b1);
    send_byte(8'h07, 1'b1);
    send_byte(8'hFF, 1'b1);
    load_window(CmdRowSet, 16'd3, 16'd2);
    write_pixels();

    for (int s = 0; s <= NumSettings; s++) begin
      if (s > 0) begin
        wait_until_drained();
        set_panel(SettingW[s-1], SettingH[s-1]);
      end
      phase_bytes = 0;
      paused = 1'b0;
      gapless_items = 40;
      while (phase_bytes < PhaseQuota) begin
        if (!paused && phase_bytes > PhaseQuota / 2) begin
          wait_until_drained();
          paused = 1'b1;
        end
        r = $urandom_range(0, 99);
        if (r < 8) begin
          noise = 8'($urandom_range(0, 255));
          if (noise >= CmdColumnSet && noise <= CmdMemWrite) noise = noise ^ 8'h80;
          send_byte(noise, 1'b0);
        end else if (r < 28) begin
          lo = pick_start(eff_w);
          load_window(CmdColumnSet, lo, pick_end(lo, 24));
        end else if (r < 45) begin
          lo = pick_start(eff_h);
          load_window(CmdRowSet, lo, pick_end(lo, 4));
        end else begin
          write_pixels();
        end
      end
    end

    wait_until_drained();
    repeat (8) @(negedge clk);
    $display("Stream of %0d command, parameter and pixel bytes plus %0d ignored bytes,",
             counted_bytes, ignored_bytes);
    $display("over %0d panel sizes: %0d pixel writes compared, %0d empty-window writes.",
             NumSettings + 1, writes_checked, empty_writes);
    if (mismatch_count == 0 && pending_writes == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
